[hw/rtl/nlp_pkg.sv]
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared widths, types and the controller command for the lexicographic
// permutation stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

  localparam int MAX_ELEMS = 16;
  localparam int ELEM_W    = 4;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = 5;
  localparam int RANK_W    = 45;
  localparam int WORD_W    = MAX_ELEMS * ELEM_W;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [WORD_W-1:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_load;
    logic take;
    logic search;
    logic commit;
  } nlp_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/nlp_cfg_if.sv]
// ----------------------------------------------------------------------------
// nlp_cfg_if
// Write channel for the element count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlp_cfg_if;
  import nlp_pkg::*;

  logic valid;
  logic ready;
  cnt_t elem_count;

  modport source (output valid, output elem_count, input ready);
  modport sink (input valid, input elem_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/nlp_req_if.sv]
// ----------------------------------------------------------------------------
// nlp_req_if
// Request channel: one advance or restart per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlp_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

[hw/rtl/nlp_rsp_if.sv]
// ----------------------------------------------------------------------------
// nlp_rsp_if
// Result channel: the new permutation, the wrap flag and the rank.
// ----------------------------------------------------------------------------
`default_nettype none

interface nlp_rsp_if;
  import nlp_pkg::*;

  logic  valid;
  logic  ready;
  word_t perm_word;
  logic  wrapped;
  rank_t rank;

  modport source (output valid, output perm_word, output wrapped, output rank,
                  input ready);
  modport sink (input valid, input perm_word, input wrapped, input rank,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/nlp_ctrl.sv]
// ----------------------------------------------------------------------------
// nlp_ctrl
// Sequencer: accept a request, run the search cycle, then the update cycle,
// and hold the result slot until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output nlp_pkg::nlp_cmd_t cmd
);
  import nlp_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       commit;
  logic       req_acc;
  logic       cfg_acc;

  // The update cycle may only retire when the result slot is free or is being
  // emptied at the same edge.
  assign commit    = (state == ST_UPDATE) && (!out_valid || rsp_ready);
  // A count write would disturb a result still waiting in the slot.
  assign cfg_ready = (state == ST_IDLE) && !out_valid;
  assign req_ready = ((state == ST_IDLE) && !cfg_valid) || commit;
  assign req_acc   = req_valid && req_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign rsp_valid = out_valid;

  assign cmd.cfg_load = cfg_acc;
  assign cmd.take     = req_acc;
  assign cmd.search   = (state == ST_SEARCH);
  assign cmd.commit   = commit;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_next = req_acc ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || rsp_ready))
    else $error("update retired into an occupied result slot");

  a_no_double_accept: assert property (@(posedge clk) disable iff (rst)
    !(cfg_acc && req_acc))
    else $error("register write and request accepted together");

  a_search_then_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |=> (state == ST_UPDATE))
    else $error("search cycle not followed by update cycle");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state == ST_SEARCH))
    else $error("accepted request did not start a search");

endmodule

`default_nettype wire

[hw/rtl/nlp_dp.sv]
// ----------------------------------------------------------------------------
// nlp_dp
// Permutation registers, pivot search, swap and tail reversal, rank counter.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_dp (
  input  logic              clk,
  input  logic              rst,
  input  nlp_pkg::nlp_cmd_t cmd,
  input  logic              req_restart,
  input  nlp_pkg::cnt_t     cfg_elem_count,
  output nlp_pkg::word_t    perm_word,
  output logic              wrapped,
  output nlp_pkg::rank_t    rank
);
  import nlp_pkg::*;

  elem_t ent      [MAX_ELEMS];
  elem_t ent_next [MAX_ELEMS];
  cnt_t  src      [MAX_ELEMS];
  cnt_t  n_q;
  cnt_t  n_sat;
  logic  restart_q;
  idx_t  k;
  idx_t  l;
  logic  found;
  elem_t pivot;
  idx_t  k_q;
  idx_t  l_q;
  logic  found_q;

  assign n_sat = (cfg_elem_count > cnt_t'(MAX_ELEMS)) ? cnt_t'(MAX_ELEMS) : cfg_elem_count;

  // Search: last ascent k, then last element after k that exceeds the pivot.
  always_comb begin
    k     = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_ELEMS - 1; i++) begin
      if ((cnt_t'(i + 2) <= n_q) && (ent[i] < ent[i + 1])) begin
        k     = idx_t'(i);
        found = 1'b1;
      end
    end
    pivot = ent[k];
    l     = '0;
    for (int j = 0; j < MAX_ELEMS; j++) begin
      if ((idx_t'(j) > k) && (cnt_t'(j) < n_q) && (ent[j] > pivot)) begin
        l = idx_t'(j);
      end
    end
  end

  // Update: position k takes the element at l; the tail is read back to front,
  // with the old pivot standing where l was.
  always_comb begin
    for (int i = 0; i < MAX_ELEMS; i++) begin
      src[i]      = cnt_t'(k_q) + n_q - cnt_t'(i);
      ent_next[i] = ent[i];
      if (idx_t'(i) == k_q) begin
        ent_next[i] = ent[l_q];
      end else if ((idx_t'(i) > k_q) && (cnt_t'(i) < n_q)) begin
        ent_next[i] = (src[i][IDX_W-1:0] == l_q) ? ent[k_q] : ent[src[i][IDX_W-1:0]];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ELEMS; i++) begin
      perm_word[i*ELEM_W +: ELEM_W] = (cnt_t'(i) < n_q) ? ent[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) restart_q <= req_restart;
    if (cmd.search) begin
      k_q     <= k;
      l_q     <= l;
      found_q <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ELEMS; i++) ent[i] <= elem_t'(i);
      n_q     <= cnt_t'(MAX_ELEMS);
      rank    <= '0;
      wrapped <= 1'b0;
    end else if (cmd.cfg_load) begin
      for (int i = 0; i < MAX_ELEMS; i++) ent[i] <= elem_t'(i);
      n_q  <= n_sat;
      rank <= '0;
    end else if (cmd.commit) begin
      if (restart_q || !found_q) begin
        for (int i = 0; i < MAX_ELEMS; i++) ent[i] <= elem_t'(i);
        rank    <= '0;
        wrapped <= !restart_q;
      end else begin
        for (int i = 0; i < MAX_ELEMS; i++) ent[i] <= ent_next[i];
        rank    <= rank + 1'b1;
        wrapped <= 1'b0;
      end
    end
  end

  a_wrap_rank_zero: assert property (@(posedge clk) disable iff (rst)
    wrapped |-> (rank == '0))
    else $error("wrap flag set with nonzero rank");

  a_advance_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !cmd.cfg_load && !restart_q && found_q)
      |=> (rank == rank_t'($past(rank) + 1'b1)))
    else $error("advance did not step the rank");

  a_cfg_clears_rank: assert property (@(posedge clk) disable iff (rst)
    cmd.cfg_load |=> (rank == '0) && (n_q <= cnt_t'(MAX_ELEMS)))
    else $error("register write left rank or count out of place");

endmodule

`default_nettype wire

[hw/rtl/next_lex_permutation_top.sv]
// ----------------------------------------------------------------------------
// next_lex_permutation_top
// Steps a permutation of up to sixteen elements through lexicographic order.
// ----------------------------------------------------------------------------
// Each request either advances the held permutation to its lexicographic
// successor or, with restart set, returns it to the identity; one result
// follows each request. A request runs a search state, which finds the last
// ascent and its swap partner among the entries, then an update state for the
// swap and tail reversal. A new request is accepted as the previous one
// retires, as long as results are taken; while a result waits in the output
// slot, the next request is searched but not retired, and the input stalls.
// Writing elem_count (saturated at sixteen) resets the permutation to the
// identity and the rank to zero; it is accepted only once the result slot is
// empty, and should be written only while no request is outstanding. After the
// descending permutation an advance wraps to the identity and sets wrapped.
`default_nettype none

module next_lex_permutation_top (
  input  logic  clk,
  input  logic  rst,
  nlp_cfg_if.sink   cfg,
  nlp_req_if.sink   req,
  nlp_rsp_if.source rsp
);
  import nlp_pkg::*;

  nlp_cmd_t cmd;

  nlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  nlp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_restart    (req.restart),
    .cfg_elem_count (cfg.elem_count),
    .perm_word      (rsp.perm_word),
    .wrapped        (rsp.wrapped),
    .rank           (rsp.rank)
  );

endmodule

`default_nettype wire
